@@ hdl/hcbd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_WIDTH_DEF = 32;
    localparam int BYTE_W         = 8;

    typedef enum logic [2:0] {
        PH_BLANK  = 3'd0,
        PH_DIGITS = 3'd1,
        PH_REST   = 3'd2,
        PH_DATA   = 3'd3,
        PH_SEP1   = 3'd4,
        PH_SEP2   = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    // One result word as it leaves the parser
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_payload;
        logic              body_done;
        logic              size_overflow;
    } result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_t h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
               (c == CH_VT) || (c == CH_FF);
    endfunction

endpackage

`default_nettype wire

@@ hdl/http_chunked_body_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// HTTP/1.1 chunked body decoder. Feed the raw bytes of a chunked message body
// on the slave stream, one byte per word, and the block returns the payload
// bytes with the chunk framing stripped. Each size line may open with blanks,
// then hex digits give the chunk size; anything else up to LF is ignored. After
// the payload the next two bytes (normally CR LF) are dropped unchecked. A size
// of zero yields one word with body_done set, after which all bytes are
// dropped until a word arrives with new_message set; that word restarts the
// parser and is itself parsed as the first byte of a size line. A size too
// large for SIZE_WIDTH bits saturates and sets size_overflow in every later
// result of the message. No other size line byte gives a word. Throughput is one
// byte per clock: the parser updates its state in the cycle a byte is taken and
// writes any result straight into a two-word output register with a skid
// stage, so s_tready depends only on a register and stays high unless the
// master side stalls for two words in a row.
module http_chunked_body_decoder #(
    parameter int SIZE_WIDTH = hcbd_pkg::SIZE_WIDTH_DEF  // 16 to 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic [0:0]  s_tuser,   // [0] new_message

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [2:0]       m_tuser    // [0] is_payload, [1] body_done, [2] size_overflow
);

    logic              in_accept;
    logic              res_valid;
    hcbd_pkg::result_t res;
    hcbd_pkg::result_t out_word;

    // a byte is taken whenever the skid stage is free
    assign in_accept = s_tvalid && s_tready;

    hcbd_parser #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_byte     (s_tdata),
        .new_message (s_tuser[0]),
        .res_valid   (res_valid),
        .res         (res)
    );

    // hold results until the master side takes them
    hcbd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (in_accept && res_valid),
        .wr_data   (res),
        .wr_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = out_word.out_byte;
    assign m_tuser = {out_word.size_overflow, out_word.body_done, out_word.is_payload};

endmodule

`default_nettype wire

@@ hdl/hcbd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hcbd_parser #(
    parameter int SIZE_WIDTH = hcbd_pkg::SIZE_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_accept,
    input  wire logic [hcbd_pkg::BYTE_W-1:0]   in_byte,
    input  wire logic                          new_message,
    output logic                               res_valid,
    output hcbd_pkg::result_t                  res
);

    hcbd_pkg::phase_t        phase_reg, phase_next, phase_cur;
    logic [SIZE_WIDTH-1:0]   acc_reg, acc_next, acc_cur;
    logic [SIZE_WIDTH-1:0]   rem_reg, rem_next, rem_cur, rem_dec;
    logic                    ovf_reg, ovf_next, ovf_cur;
    hcbd_pkg::hex_t          hex;
    logic                    is_lf;
    logic [SIZE_WIDTH-1:0]   acc_digit;
    logic                    acc_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hcbd_pkg::PH_BLANK;
            acc_reg   <= '0;
            rem_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb begin
        // new message: start over at a size line before this byte
        phase_cur = new_message ? hcbd_pkg::PH_BLANK : phase_reg;
        acc_cur   = new_message ? '0 : acc_reg;
        rem_cur   = new_message ? '0 : rem_reg;
        ovf_cur   = new_message ? 1'b0 : ovf_reg;

        hex       = hcbd_pkg::hex_decode(in_byte);
        is_lf     = (in_byte == hcbd_pkg::CH_LF);
        acc_sat   = (acc_cur[SIZE_WIDTH-1 -: 4] != 4'd0);
        acc_digit = {acc_cur[SIZE_WIDTH-5:0], hex.value};
        rem_dec   = rem_cur - SIZE_WIDTH'(1);

        phase_next = phase_cur;
        acc_next   = acc_cur;
        rem_next   = rem_cur;
        ovf_next   = ovf_cur;

        res_valid         = 1'b0;
        res.out_byte      = '0;
        res.is_payload    = 1'b0;
        res.body_done     = 1'b0;
        res.size_overflow = ovf_cur;

        unique case (phase_cur)
            hcbd_pkg::PH_BLANK, hcbd_pkg::PH_DIGITS, hcbd_pkg::PH_REST: begin
                if (is_lf) begin
                    if (acc_cur == '0) begin
                        phase_next    = hcbd_pkg::PH_DONE;
                        res_valid     = 1'b1;
                        res.body_done = 1'b1;
                    end else begin
                        rem_next   = acc_cur;
                        acc_next   = '0;
                        phase_next = hcbd_pkg::PH_DATA;
                    end
                end else if (phase_cur != hcbd_pkg::PH_REST && hex.is_hex) begin
                    // saturate rather than wrap when a digit would overflow
                    if (acc_sat) begin
                        acc_next = '1;
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = acc_digit;
                    end
                    phase_next = hcbd_pkg::PH_DIGITS;
                end else if (phase_cur == hcbd_pkg::PH_DIGITS ||
                             (phase_cur == hcbd_pkg::PH_BLANK &&
                              !hcbd_pkg::is_blank(in_byte))) begin
                    phase_next = hcbd_pkg::PH_REST;
                end
            end
            hcbd_pkg::PH_DATA: begin
                res_valid      = 1'b1;
                res.out_byte   = in_byte;
                res.is_payload = 1'b1;
                rem_next       = rem_dec;
                if (rem_dec == '0) begin
                    phase_next = hcbd_pkg::PH_SEP1;
                end
            end
            hcbd_pkg::PH_SEP1: begin
                phase_next = hcbd_pkg::PH_SEP2;
            end
            hcbd_pkg::PH_SEP2: begin
                phase_next = hcbd_pkg::PH_BLANK;
                acc_next   = '0;
            end
            default: begin
                phase_next = hcbd_pkg::PH_DONE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/hcbd_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hcbd_out_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  wire hcbd_pkg::result_t wr_data,
    output logic                   wr_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hcbd_pkg::result_t      out_data
);

    logic              main_valid_reg;
    hcbd_pkg::result_t main_data_reg;
    logic              skid_valid_reg;
    hcbd_pkg::result_t skid_data_reg;
    logic              pop;

    assign pop       = main_valid_reg && out_ready;
    assign wr_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // drain the skid word into the output register
            if (pop) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (wr_en) begin
            if (!main_valid_reg || pop) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (wr_en) begin
            if (!main_valid_reg || pop) begin
                main_data_reg <= wr_data;
            end else begin
                skid_data_reg <= wr_data;
            end
        end
    end

    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid word held without an output word");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(main_valid_reg && !out_ready && wr_en))
        else $error("skid filled while output was free");

    a_no_write_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !wr_en)
        else $error("write while both stages full");

    a_skid_moves_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && pop) |=> (main_data_reg == $past(skid_data_reg)))
        else $error("skid word lost on drain");

endmodule

`default_nettype wire
